// ----- rtl/core/gzfd_pkg.sv -----
// ----------------------------------------------------------------------------
// gzfd_pkg
// Shared sizes, codes and handshake types of the ground-zone fall detector.
// ----------------------------------------------------------------------------
package gzfd_pkg;

    // image and history geometry
    localparam int IMAGE_ROWS    = 8;
    localparam int IMAGE_COLS    = 32;
    localparam int HISTORY_DEPTH = 8;
    localparam int FRAME_PIXELS  = IMAGE_ROWS * IMAGE_COLS;

    // field widths
    localparam int DIST_W  = 16;
    localparam int THR_W   = 7;
    localparam int ROWSEL_W = 3;
    localparam int EVT_W   = 2;
    localparam int CONF_W  = 7;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived internal widths
    localparam int ROW_W  = $clog2(IMAGE_ROWS + 1);
    localparam int COL_W  = (IMAGE_COLS > 1) ? $clog2(IMAGE_COLS) : 1;
    localparam int CNT_W  = $clog2(FRAME_PIXELS + 1);
    localparam int ZSUM_W = DIST_W + CNT_W;
    localparam int HIDX_W = $clog2(HISTORY_DEPTH);
    localparam int SSUM_W = DIST_W + HIDX_W;
    localparam int MULB_W = 13;
    localparam int PROD_W = SSUM_W + MULB_W;
    localparam int DIVD_W = (PROD_W > ZSUM_W) ? PROD_W : ZSUM_W;
    localparam int DIVS_W = SSUM_W + THR_W;
    localparam int DCNT_W = $clog2(DIVD_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUND_ROW = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0]    RST_THRESHOLD  = 7'd80;
    localparam logic [DIST_W-1:0]   RST_FALL_MAX   = 16'd1500;
    localparam logic [DIST_W-1:0]   RST_VALID_MAX  = 16'd5000;
    localparam logic [ROWSEL_W-1:0] RST_GROUND_ROW = 3'd6;

    // event codes
    localparam logic [EVT_W-1:0] EVT_NORMAL   = 2'd0;
    localparam logic [EVT_W-1:0] EVT_ABNORMAL = 2'd1;
    localparam logic [EVT_W-1:0] EVT_FALL     = 2'd2;

    // classification constants
    localparam logic [MULB_W-1:0] PCT_FALL = 13'd100;
    localparam logic [MULB_W-1:0] PCT_ABN  = 13'd200;
    localparam logic [MULB_W-1:0] K_FALL   = 13'd5000;
    localparam logic [MULB_W-1:0] K_ABN    = 13'd4000;
    localparam logic [CONF_W-1:0] CONF_MAX = 7'd100;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/gzfd_div.sv -----
// ----------------------------------------------------------------------------
// gzfd_div
// Restoring divider, one quotient bit per cycle, done pulse once all DIVD_W quotient bits are in.
// ----------------------------------------------------------------------------
module gzfd_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  gzfd_pkg::div_req_t  req,
    output gzfd_pkg::div_rsp_t  rsp
);
    import gzfd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg, dsr_next;

    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] trial_sub;
    logic            trial_ge;

    assign trial     = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial_ge  = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = trial_ge ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], trial_ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/core/ground_zone_fall_detector_top.sv -----
// Sequencing: each pixel is accumulated as it arrives; after the last pixel the result is formed
//   by an averaging divide (skipped for an empty zone), a walk over any earlier history entries,
//   multiply and compare steps and a confidence divide for a fall or abnormal result.
// Throughput: one pixel per cycle within a frame; no input is taken while a frame result
//   is being computed or waits for the output register to be freed.
// Synchronous active-low reset: register defaults, empty history, no pending result.
// ----------------------------------------------------------------------------
// ground_zone_fall_detector_top
// Averages valid ground-zone depth pixels per frame and classifies the drop
// against the recent history as normal, abnormal movement or fall.
// ----------------------------------------------------------------------------
module ground_zone_fall_detector_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gzfd_pkg::IN_W-1:0]           s_tdata,   // [15:0] distance_mm
    input  logic                                s_tlast,   // end_of_frame
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] event_state, [8:2] confidence, [24:9] ground_avg_mm, rest zero
    output logic [gzfd_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                cfg_we,
    input  logic [gzfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gzfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import gzfd_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_AVG_GO    = 4'd1;
    localparam logic [3:0] ST_AVG_WAIT  = 4'd2;
    localparam logic [3:0] ST_PUSH      = 4'd3;
    localparam logic [3:0] ST_SUM       = 4'd4;
    localparam logic [3:0] ST_MUL_NA    = 4'd5;
    localparam logic [3:0] ST_MUL_T     = 4'd6;
    localparam logic [3:0] ST_MUL_100   = 4'd7;
    localparam logic [3:0] ST_CMP_100   = 4'd8;
    localparam logic [3:0] ST_CMP_200   = 4'd9;
    localparam logic [3:0] ST_MUL_K     = 4'd10;
    localparam logic [3:0] ST_CONF_GO   = 4'd11;
    localparam logic [3:0] ST_CONF_WAIT = 4'd12;
    localparam logic [3:0] ST_DONE      = 4'd13;

    // configuration
    logic [THR_W-1:0]    thr_reg;
    logic [DIST_W-1:0]   fmax_reg;
    logic [DIST_W-1:0]   vmax_reg;
    logic [ROWSEL_W-1:0] fgr_reg;

    // sequencer and datapath
    logic [3:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ZSUM_W-1:0] zsum_reg, zsum_next;
    logic [CNT_W-1:0]  zcnt_reg, zcnt_next;
    logic [DIST_W-1:0] avg_reg, avg_next;
    logic [HIDX_W-1:0] wslot_reg, wslot_next;
    logic              filled_reg, filled_next;
    logic [HIDX_W-1:0] ptr_reg, ptr_next;
    logic [HIDX_W-1:0] iter_reg, iter_next;
    logic [HIDX_W-1:0] n_reg, n_next;
    logic [SSUM_W-1:0] ssum_reg, ssum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SSUM_W-1:0] diff_reg, diff_next;
    logic [DIVS_W-1:0] t_reg, t_next;
    logic [EVT_W-1:0]  evt_reg, evt_next;
    logic [CONF_W-1:0] conf_reg, conf_next;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic [DIST_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [DIST_W-1:0] hist_rd_reg;
    logic              hist_we;

    // shared multiplier
    logic [SSUM_W-1:0] mul_a;
    logic [MULB_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic              pix_accept;
    logic              pix_in_zone;
    logic [DIST_W-1:0] pix_dist;
    logic [THR_W-1:0]  thr_eff;
    logic              filled_new;
    logic [HIDX_W-1:0] n_new;

    assign s_tready   = (state_reg == ST_IDLE);
    assign pix_accept = s_tvalid && s_tready;
    assign pix_dist   = s_tdata[DIST_W-1:0];
    assign thr_eff    = (thr_reg == '0) ? THR_W'(1) : thr_reg;

    assign pix_in_zone = (row_reg < ROW_W'(IMAGE_ROWS))
                      && (row_reg >= ROW_W'(fgr_reg))
                      && (pix_dist != '0) && (pix_dist < vmax_reg);

    assign filled_new = filled_reg || (wslot_reg == HIDX_W'(HISTORY_DEPTH - 1));
    assign n_new      = filled_new ? HIDX_W'(HISTORY_DEPTH - 1) : wslot_reg;

    assign mul_p = {{MULB_W{1'b0}}, mul_a} * {{SSUM_W{1'b0}}, mul_b};

    gzfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= RST_THRESHOLD;
            fmax_reg <= RST_FALL_MAX;
            vmax_reg <= RST_VALID_MAX;
            fgr_reg  <= RST_GROUND_ROW;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:  thr_reg  <= cfg_wdata[THR_W-1:0];
                REG_FALL_MAX:   fmax_reg <= cfg_wdata[DIST_W-1:0];
                REG_VALID_MAX:  vmax_reg <= cfg_wdata[DIST_W-1:0];
                REG_GROUND_ROW: fgr_reg  <= cfg_wdata[ROWSEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        zsum_next    = zsum_reg;
        zcnt_next    = zcnt_reg;
        avg_next     = avg_reg;
        wslot_next   = wslot_reg;
        filled_next  = filled_reg;
        ptr_next     = ptr_reg;
        iter_next    = iter_reg;
        n_next       = n_reg;
        ssum_next    = ssum_reg;
        prod_next    = prod_reg;
        diff_next    = diff_reg;
        t_next       = t_reg;
        evt_next     = evt_reg;
        conf_next    = conf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        hist_we      = 1'b0;
        mul_a        = diff_reg;
        mul_b        = PCT_FALL;
        div_req.start    = 1'b0;
        div_req.dividend = DIVD_W'(zsum_reg);
        div_req.divisor  = DIVS_W'(zcnt_reg);

        case (state_reg)
            ST_IDLE: begin
                if (pix_accept) begin
                    if (row_reg < ROW_W'(IMAGE_ROWS)) begin
                        if (pix_in_zone) begin
                            zsum_next = zsum_reg + ZSUM_W'(pix_dist);
                            zcnt_next = zcnt_reg + 1'b1;
                        end
                        if (col_reg == COL_W'(IMAGE_COLS - 1)) begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        state_next = ST_AVG_GO;
                    end
                end
            end
            ST_AVG_GO: begin
                if (zcnt_reg == '0) begin
                    avg_next   = '0;
                    state_next = ST_PUSH;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_AVG_WAIT;
                end
            end
            ST_AVG_WAIT: begin
                if (div_rsp.done) begin
                    avg_next   = div_rsp.quotient[DIST_W-1:0];
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                hist_we     = 1'b1;
                row_next    = '0;
                col_next    = '0;
                zsum_next   = '0;
                zcnt_next   = '0;
                evt_next    = EVT_NORMAL;
                conf_next   = '0;
                ssum_next   = '0;
                filled_next = filled_new;
                wslot_next  = (wslot_reg == HIDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : wslot_reg + 1'b1;
                // walk backward from the entry before the one just written
                ptr_next    = (wslot_reg == '0) ? HIDX_W'(HISTORY_DEPTH - 1)
                                                : wslot_reg - 1'b1;
                n_next      = n_new;
                iter_next   = n_new;
                state_next  = (n_new == '0) ? ST_DONE : ST_SUM;
            end
            ST_SUM: begin
                ssum_next = ssum_reg + SSUM_W'(hist_rd_reg);
                ptr_next  = (ptr_reg == '0) ? HIDX_W'(HISTORY_DEPTH - 1) : ptr_reg - 1'b1;
                iter_next = iter_reg - 1'b1;
                if (iter_reg == HIDX_W'(1)) begin
                    state_next = ST_MUL_NA;
                end
            end
            ST_MUL_NA: begin
                // earlier mean below 1 mm: stays normal
                if (ssum_reg < SSUM_W'(n_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    mul_a      = SSUM_W'(avg_reg);
                    mul_b      = MULB_W'(n_reg);
                    prod_next  = mul_p;
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T: begin
                if (PROD_W'(ssum_reg) <= prod_reg) begin
                    state_next = ST_DONE;
                end else begin
                    diff_next  = ssum_reg - prod_reg[SSUM_W-1:0];
                    mul_a      = ssum_reg;
                    mul_b      = MULB_W'(thr_eff);
                    prod_next  = mul_p;
                    state_next = ST_MUL_100;
                end
            end
            ST_MUL_100: begin
                t_next     = prod_reg[DIVS_W-1:0];
                mul_a      = diff_reg;
                mul_b      = PCT_FALL;
                prod_next  = mul_p;
                state_next = ST_CMP_100;
            end
            ST_CMP_100: begin
                if ((prod_reg >= PROD_W'(t_reg)) && (avg_reg < fmax_reg)) begin
                    evt_next   = EVT_FALL;
                    state_next = ST_MUL_K;
                end else begin
                    mul_a      = diff_reg;
                    mul_b      = PCT_ABN;
                    prod_next  = mul_p;
                    state_next = ST_CMP_200;
                end
            end
            ST_CMP_200: begin
                if (prod_reg >= PROD_W'(t_reg)) begin
                    evt_next   = EVT_ABNORMAL;
                    state_next = ST_MUL_K;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_K: begin
                mul_a      = diff_reg;
                mul_b      = (evt_reg == EVT_FALL) ? K_FALL : K_ABN;
                prod_next  = mul_p;
                state_next = ST_CONF_GO;
            end
            ST_CONF_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVD_W'(prod_reg);
                div_req.divisor  = t_reg;
                state_next       = ST_CONF_WAIT;
            end
            ST_CONF_WAIT: begin
                if (div_rsp.done) begin
                    conf_next  = (div_rsp.quotient > DIVD_W'(CONF_MAX))
                               ? CONF_MAX : div_rsp.quotient[CONF_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({avg_reg, conf_reg, evt_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            zsum_reg    <= '0;
            zcnt_reg    <= '0;
            wslot_reg   <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            zsum_reg    <= zsum_next;
            zcnt_reg    <= zcnt_next;
            wslot_reg   <= wslot_next;
            filled_reg  <= filled_next;
            m_valid_reg <= m_valid_next;
        end
        avg_reg    <= avg_next;
        ptr_reg    <= ptr_next;
        iter_reg   <= iter_next;
        n_reg      <= n_next;
        ssum_reg   <= ssum_next;
        prod_reg   <= prod_next;
        diff_reg   <= diff_next;
        t_reg      <= t_next;
        evt_reg    <= evt_next;
        conf_reg   <= conf_next;
        m_data_reg <= m_data_next;
    end

    // read address runs one step ahead, so the read data lines up with ptr_reg
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[wslot_reg] <= avg_reg;
        end
        hist_rd_reg <= hist_mem[ptr_next];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_fall_conf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[1:0] == EVT_FALL)) |-> (m_data_reg[8:2] >= 7'd50))
        else $error("fall result with confidence below 50");

    a_abn_conf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[1:0] == EVT_ABNORMAL)) |-> (m_data_reg[8:2] >= 7'd20))
        else $error("abnormal result with confidence below 20");

    a_normal_conf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[1:0] == EVT_NORMAL)) |-> (m_data_reg[8:2] == '0))
        else $error("normal result with nonzero confidence");

    a_pending_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_tready)
        |=> (state_reg == ST_DONE && $stable(m_data_reg)))
        else $error("pending result overwritten");

    a_sum_iter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (iter_reg != '0))
        else $error("history walk with zero entries left");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ground-zone fall detector testbench
// Streams depth frames of mixed length into the detector, tracks the zone
// average and the history ring in a local predictor, and compares every
// frame report field by field. Directed frames first, then random scenes
// whose level drifts and drops, under random idle on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import gzfd_pkg::*;

    localparam int MAX_IDLE       = 15;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 120;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PIXELS  = 200;
    localparam int RANDOM_FRAMES  = 16;
    localparam int PHASE_FRAMES   = 8;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic [EVT_W-1:0]  state;
        logic [CONF_W-1:0] conf;
        logic [DIST_W-1:0] avg;
    } fall_report_t;

    typedef enum logic {ROW_CONFIG, ROW_FRAME} stim_kind_t;

    typedef struct {
        stim_kind_t             kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        int                     length;
        logic [DIST_W-1:0]      distance;
        bit                     typed;
        fall_report_t           want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    ground_zone_fall_detector_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow registers
    logic [THR_W-1:0]    cfg_threshold  = RST_THRESHOLD;
    logic [DIST_W-1:0]   cfg_fall_max   = RST_FALL_MAX;
    logic [DIST_W-1:0]   cfg_valid_max  = RST_VALID_MAX;
    logic [ROWSEL_W-1:0] cfg_ground_row = RST_GROUND_ROW;

    // predicted frame state
    int unsigned       frame_pos   = 0;
    longint unsigned   zone_sum    = 0;
    int unsigned       zone_count  = 0;
    logic [DIST_W-1:0] avg_history [HISTORY_DEPTH] = '{default: '0};
    int unsigned       history_slot = 0;
    bit                ring_wrapped = 1'b0;

    fall_report_t expected_reports[$];

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;

    int mismatch_count = 0;
    int total_pixels   = 0;
    int total_frames   = 0;
    int random_pixels  = 0;
    int random_frames  = 0;
    int config_writes  = 0;
    int fall_seen      = 0;
    int abnormal_seen  = 0;
    int normal_seen    = 0;
    int unsigned cycle_count = 0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // lone pixel in row 0, outside the default zone, history too short
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd1000,  1'b1, '{EVT_NORMAL, 7'd0, 16'd0}},
        '{ROW_CONFIG, REG_GROUND_ROW, 16'd0,     0, 16'd0,     1'b0, '0},
        // earlier mean below one mm
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     2, 16'd1000,  1'b1, '{EVT_NORMAL, 7'd0, 16'd1000}},
        // no return at all: full drop against 500 mm mean
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     3, 16'd0,     1'b1, '{EVT_FALL, 7'd62, 16'd0}},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     3, 16'd65535, 1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     2, 16'd4999,  1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd1,     1'b0, '0},
        '{ROW_CONFIG, REG_VALID_MAX,  16'd65535, 0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd65535, 1'b0, '0},
        // whole image in the zone at near full scale, frame runs past the image size
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,   264, 16'd65534, 1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     3, 16'd3000,  1'b0, '0},
        '{ROW_CONFIG, REG_THRESHOLD,  16'd0,     0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd100,   1'b0, '0},
        '{ROW_CONFIG, REG_THRESHOLD,  16'd127,   0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd50,    1'b0, '0},
        '{ROW_CONFIG, REG_FALL_MAX,   16'd0,     0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd0,     1'b0, '0},
        '{ROW_CONFIG, REG_FALL_MAX,   16'd65535, 0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     1, 16'd0,     1'b0, '0},
        '{ROW_CONFIG, REG_VALID_MAX,  16'd0,     0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,     4, 16'd123,   1'b0, '0},
        '{ROW_CONFIG, REG_VALID_MAX,  16'd5000,  0, 16'd0,     1'b0, '0},
        '{ROW_CONFIG, REG_GROUND_ROW, 16'd7,     0, 16'd0,     1'b0, '0},
        '{ROW_FRAME,  REG_THRESHOLD,  16'd0,   232, 16'd2000,  1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Accumulates one pixel; on end of frame closes the average, pushes it into
    // the ring and classifies it against the earlier window entries.
    function automatic bit predict_report(input logic [DIST_W-1:0] distance, input bit eof,
                                          output fall_report_t rpt);
        int unsigned     row, avg, len, n, idx;
        longint unsigned ref_sum, scaled_thr, drop, quot;
        longint          diff;
        rpt = '0;
        if (frame_pos < FRAME_PIXELS) begin
            row = frame_pos / IMAGE_COLS;
            if (row >= cfg_ground_row && distance != 0 && distance < cfg_valid_max) begin
                zone_sum += distance;
                zone_count++;
            end
            frame_pos++;
        end
        if (!eof)
            return 1'b0;

        avg = (zone_count > 0) ? int'(zone_sum / zone_count) : 0;
        frame_pos  = 0;
        zone_sum   = 0;
        zone_count = 0;
        avg_history[history_slot] = avg[DIST_W-1:0];
        history_slot = (history_slot + 1) % HISTORY_DEPTH;
        if (history_slot == 0)
            ring_wrapped = 1'b1;
        len = ring_wrapped ? HISTORY_DEPTH : history_slot;

        rpt.state = EVT_NORMAL;
        rpt.avg   = avg[DIST_W-1:0];
        if (len >= 2) begin
            n = len - 1;
            ref_sum = 0;
            for (int i = 0; i < n; i++) begin
                idx = (history_slot + HISTORY_DEPTH - len + i) % HISTORY_DEPTH;
                ref_sum += avg_history[idx];
            end
            if (ref_sum >= n) begin
                scaled_thr = (cfg_threshold == 0 ? 1 : cfg_threshold) * ref_sum;
                diff = longint'(ref_sum) - longint'(n) * longint'(avg);
                if (diff > 0) begin
                    drop = diff;
                    if (100 * drop >= scaled_thr && avg < cfg_fall_max) begin
                        rpt.state = EVT_FALL;
                        quot = 5000 * drop / scaled_thr;
                        rpt.conf = (quot > CONF_MAX) ? CONF_MAX : quot[CONF_W-1:0];
                    end else if (200 * drop >= scaled_thr) begin
                        rpt.state = EVT_ABNORMAL;
                        quot = 4000 * drop / scaled_thr;
                        rpt.conf = (quot > CONF_MAX) ? CONF_MAX : quot[CONF_W-1:0];
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    // pixel around the scene level, with dropouts, range edges and raw noise
    function automatic logic [DIST_W-1:0] scene_pixel(input int level);
        int pick, spread, v;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return '0;
        if (pick < 12)
            return cfg_valid_max;
        if (pick < 15)
            return cfg_valid_max - 1'b1;
        if (pick < 22)
            return DIST_W'($urandom);
        spread = level / 16 + 1;
        v = level - spread + int'($urandom_range(0, 2 * spread));
        if (v < 1)
            v = 1;
        if (v > 65535)
            v = 65535;
        return v[DIST_W-1:0];
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_THRESHOLD:  cfg_threshold  = value[THR_W-1:0];
            REG_FALL_MAX:   cfg_fall_max   = value[DIST_W-1:0];
            REG_VALID_MAX:  cfg_valid_max  = value[DIST_W-1:0];
            REG_GROUND_ROW: cfg_ground_row = value[ROWSEL_W-1:0];
            default: ;
        endcase
        config_writes++;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // drain all reports, then let the block finish any frame-end work
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // entered and left at a rising edge; valid stays up between back-to-back transfers
    task automatic send_pixel(input logic [DIST_W-1:0] distance, input bit eof,
                              input bit typed, input fall_report_t typed_rpt);
        int gap;
        fall_report_t rpt;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= distance;
        s_tlast  <= eof;
        do @(negedge aclk); while (s_tready !== 1'b1);
        if (predict_report(distance, eof, rpt))
            expected_reports.push_back(typed ? typed_rpt : rpt);
        total_pixels++;
        if (eof)
            total_frames++;
        @(posedge aclk);
    endtask

    initial begin : result_sink
        int gap;
        fall_report_t want, got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (m_tvalid !== 1'b1);
            got.state = m_tdata[EVT_W-1:0];
            got.conf  = m_tdata[EVT_W +: CONF_W];
            got.avg   = m_tdata[EVT_W+CONF_W +: DIST_W];
            if (expected_reports.size() == 0) begin
                $display("%0t: report with none expected: state %0d conf %0d avg %0d",
                         $time, got.state, got.conf, got.avg);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got.state !== want.state) begin
                    $display("%0t: event_state expected %0d actual %0d",
                             $time, want.state, got.state);
                    mismatch_count++;
                end
                if (got.conf !== want.conf) begin
                    $display("%0t: confidence expected %0d actual %0d",
                             $time, want.conf, got.conf);
                    mismatch_count++;
                end
                if (got.avg !== want.avg) begin
                    $display("%0t: ground_avg_mm expected %0d actual %0d",
                             $time, want.avg, got.avg);
                    mismatch_count++;
                end
                case (want.state)
                    EVT_FALL:     fall_seen++;
                    EVT_ABNORMAL: abnormal_seen++;
                    default:      normal_seen++;
                endcase
            end
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int phase, pick, len, base_level, level;
        logic [CFG_DATA_W-1:0] value;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_CONFIG) begin
                wait_quiet();
                write_register(directed_rows[r].reg_index, directed_rows[r].reg_value);
            end else begin
                for (int p = 0; p < directed_rows[r].length; p++)
                    send_pixel(directed_rows[r].distance, p == directed_rows[r].length - 1,
                               directed_rows[r].typed, directed_rows[r].want);
            end
        end

        phase = 0;
        while (random_pixels < RANDOM_PIXELS || random_frames < RANDOM_FRAMES) begin
            wait_quiet();

            pick = $urandom_range(0, 5);
            case (pick)
                0:       value = 16'd0;
                1:       value = 16'd1;
                2:       value = 16'd100;
                3:       value = 16'd127;
                default: value = CFG_DATA_W'($urandom_range(1, 100));
            endcase
            write_register(REG_THRESHOLD, value);

            pick = $urandom_range(0, 4);
            case (pick)
                0:       value = 16'd0;
                1:       value = 16'd65535;
                2:       value = 16'd1500;
                3:       value = CFG_DATA_W'($urandom_range(0, 65535));
                default: value = CFG_DATA_W'($urandom_range(500, 5000));
            endcase
            write_register(REG_FALL_MAX, value);

            pick = $urandom_range(0, 9);
            case (pick)
                0:       value = 16'd0;
                1:       value = 16'd1;
                2:       value = 16'd65535;
                3:       value = 16'd5000;
                default: value = CFG_DATA_W'($urandom_range(1000, 65535));
            endcase
            write_register(REG_VALID_MAX, value);

            // short frames only reach the zone when it starts near the top
            value = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 7)) : '0;
            write_register(REG_GROUND_ROW, value);

            // first phase: back-to-back pixels against a long output stall
            if (phase == 0)
                hold_request = 1'b1;
            tx_idle_on = (phase == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            rx_idle_on = $urandom_range(0, 2) != 0;

            base_level = $urandom_range(600, 4500);
            level = base_level;
            for (int f = 0; f < PHASE_FRAMES; f++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    level = level;
                else if (pick < 80)
                    level = base_level * int'($urandom_range(10, 75)) / 100;
                else if (pick < 92)
                    level = base_level;
                else
                    level = $urandom_range(100, 8000);

                pick = $urandom_range(0, 99);
                if (pick < 3)
                    len = FRAME_PIXELS;
                else if (pick < 5)
                    len = $urandom_range(FRAME_PIXELS + 1, FRAME_PIXELS + 24);
                else
                    len = $urandom_range(1, 10);

                for (int p = 0; p < len; p++)
                    send_pixel(scene_pixel(level), p == len - 1, 1'b0, '0);
                random_pixels += len;
                random_frames++;
            end
            phase++;
        end

        wait_quiet();
        $display("Sent %0d pixels in %0d frames over %0d random scenes, %0d register writes",
                 total_pixels, total_frames, phase, config_writes);
        $display("Reports: %0d fall, %0d abnormal, %0d normal; %0d mismatches",
                 fall_seen, abnormal_seen, normal_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
